>>> src/tkn_pkg.sv
// Shared types, constants and helper functions for the command line tokenizer.
// No dependencies; every other file imports this package.
package tkn_pkg;

  localparam int KW_CHARS      = 10;
  localparam int POS_BITS      = 16;
  localparam int FIELD_BITS    = 16;
  localparam int KW_COUNT      = 14;
  localparam int KW_TEXT_CHARS = 10;
  localparam int KW_LEN_BITS   = $clog2(KW_TEXT_CHARS + 1);
  localparam int WIDX_BITS     = $clog2(KW_CHARS);

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_END        = 5'd0;
  localparam kind_t KIND_NUMBER     = 5'd1;
  localparam kind_t KIND_IDENT      = 5'd2;
  localparam kind_t KIND_FIRST_KW   = 5'd3;
  localparam kind_t KIND_DASH       = 5'd17;
  localparam kind_t KIND_DOT        = 5'd18;
  localparam kind_t KIND_COLON      = 5'd19;
  localparam kind_t KIND_SEMI       = 5'd20;
  localparam kind_t KIND_EQUAL      = 5'd21;
  localparam kind_t KIND_SLASH      = 5'd22;
  localparam kind_t KIND_UNKNOWN    = 5'd23;

  typedef logic [KW_CHARS-1:0][7:0]    word_buf_t;
  typedef logic [KW_TEXT_CHARS*8-1:0]  kw_text_t;

  // Text is right aligned: first character in the highest used byte.
  localparam kw_text_t KW_TEXT [KW_COUNT] = '{
    "help", "save", "read", "add", "undo", "redo", "ls", "con", "cd", "cur",
    "disconnect", "set", "hist", "state"
  };

  localparam logic [KW_LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
    KW_LEN_BITS'(4), KW_LEN_BITS'(4), KW_LEN_BITS'(4), KW_LEN_BITS'(3),
    KW_LEN_BITS'(4), KW_LEN_BITS'(4), KW_LEN_BITS'(2), KW_LEN_BITS'(3),
    KW_LEN_BITS'(2), KW_LEN_BITS'(3), KW_LEN_BITS'(10), KW_LEN_BITS'(3),
    KW_LEN_BITS'(4), KW_LEN_BITS'(5)
  };

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] line;
    logic [FIELD_BITS-1:0] column;
    logic [FIELD_BITS-1:0] offset;
    logic [FIELD_BITS-1:0] length;
    logic                  last;
  } token_t;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [POS_BITS-1:0] v);
    return FIELD_BITS'(v);
  endfunction

  function automatic kind_t kw_kind(input word_buf_t chars, input logic [POS_BITS-1:0] len);
    kind_t  k;
    logic   hit;
    k = KIND_IDENT;
    for (int w = KW_COUNT - 1; w >= 0; w--) begin
      hit = (len == POS_BITS'(KW_LEN[w]));
      for (int i = 0; i < KW_TEXT_CHARS; i++) begin
        if (i < int'(KW_LEN[w])) begin
          hit = hit && (chars[i] == KW_TEXT[w][(int'(KW_LEN[w]) - 1 - i) * 8 +: 8]);
        end
      end
      if (hit) begin
        k = KIND_FIRST_KW + kind_t'(w);
      end
    end
    return k;
  endfunction

endpackage

>>> src/tkn_scan.sv
// Scanner state and per-byte token decode: up to two tokens per transfer.
// Depends on tkn_pkg.
module tkn_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         in_byte,
  output logic [1:0]         push_count,
  output tkn_pkg::token_t    rec0,
  output tkn_pkg::token_t    rec1
);
  import tkn_pkg::*;

  typedef enum logic [1:0] {MODE_IDLE, MODE_NUMBER, MODE_WORD} mode_t;

  mode_t               mode;
  word_buf_t           word_chars;
  logic [POS_BITS-1:0] pending_length;
  logic [POS_BITS-1:0] current_line;
  logic [POS_BITS-1:0] current_column;
  logic [POS_BITS-1:0] byte_offset;
  logic [POS_BITS-1:0] pending_start_line;
  logic [POS_BITS-1:0] pending_start_column;
  logic [POS_BITS-1:0] pending_start_offset;

  logic   is_digit, is_alpha, is_space, is_word;
  logic   cont, flush, has_sec;
  token_t flush_rec, sec_rec;
  kind_t  punct_kind;

  always_comb begin
    is_digit = in_byte inside {[8'h30:8'h39]};
    is_alpha = in_byte inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    is_space = in_byte inside {8'h20, [8'h09:8'h0d]};
    is_word  = is_alpha || is_digit || (in_byte == 8'h5f);
    cont     = ((mode == MODE_NUMBER) && is_digit) || ((mode == MODE_WORD) && is_word);
    flush    = !cont && (mode != MODE_IDLE);

    case (in_byte)
      8'h2d:   punct_kind = KIND_DASH;
      8'h2e:   punct_kind = KIND_DOT;
      8'h3a:   punct_kind = KIND_COLON;
      8'h3b:   punct_kind = KIND_SEMI;
      8'h3d:   punct_kind = KIND_EQUAL;
      8'h2f:   punct_kind = KIND_SLASH;
      default: punct_kind = KIND_UNKNOWN;
    endcase

    flush_rec.kind   = (mode == MODE_NUMBER) ? KIND_NUMBER
                     : ((pending_length > POS_BITS'(KW_CHARS)) ? KIND_IDENT
                        : kw_kind(word_chars, pending_length));
    flush_rec.line   = to_field(pending_start_line);
    flush_rec.column = to_field(pending_start_column);
    flush_rec.offset = to_field(pending_start_offset);
    flush_rec.length = to_field(pending_length);
    flush_rec.last   = 1'b0;

    has_sec = !cont && !is_space && !is_digit && !(is_alpha || in_byte == 8'h5f);
    sec_rec.kind   = (in_byte == 8'h00) ? KIND_END : punct_kind;
    sec_rec.line   = to_field(current_line);
    sec_rec.column = to_field(current_column);
    sec_rec.offset = to_field(byte_offset);
    sec_rec.length = (in_byte == 8'h00) ? '0 : FIELD_BITS'(1);
    sec_rec.last   = 1'b1;

    rec1 = sec_rec;
    if (flush) begin
      rec0      = flush_rec;
      rec0.last = !has_sec;
    end else begin
      rec0 = sec_rec;
    end
    push_count = fire ? (2'(flush) + 2'(has_sec)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                 <= MODE_IDLE;
      pending_length       <= '0;
      current_line         <= POS_BITS'(1);
      current_column       <= POS_BITS'(1);
      byte_offset          <= '0;
      pending_start_line   <= POS_BITS'(1);
      pending_start_column <= POS_BITS'(1);
      pending_start_offset <= '0;
    end else if (fire) begin
      if (in_byte == 8'h00) begin
        mode                 <= MODE_IDLE;
        pending_length       <= '0;
        current_line         <= POS_BITS'(1);
        current_column       <= POS_BITS'(1);
        byte_offset          <= '0;
        pending_start_line   <= POS_BITS'(1);
        pending_start_column <= POS_BITS'(1);
        pending_start_offset <= '0;
      end else begin
        byte_offset <= sat_inc(byte_offset);
        if (in_byte == 8'h0a) begin
          current_line   <= sat_inc(current_line);
          current_column <= POS_BITS'(1);
        end else begin
          current_column <= sat_inc(current_column);
        end
        if (cont) begin
          pending_length <= sat_inc(pending_length);
        end else if (is_digit || is_alpha || in_byte == 8'h5f) begin
          mode                 <= is_digit ? MODE_NUMBER : MODE_WORD;
          pending_length       <= POS_BITS'(1);
          pending_start_line   <= current_line;
          pending_start_column <= current_column;
          pending_start_offset <= byte_offset;
        end else begin
          mode           <= MODE_IDLE;
          pending_length <= '0;
        end
      end
    end
  end

  // Word buffer: only the first KW_CHARS characters are kept.
  always_ff @(posedge clk) begin
    if (fire && in_byte != 8'h00) begin
      if (cont && mode == MODE_WORD) begin
        if (pending_length < POS_BITS'(KW_CHARS)) begin
          word_chars[pending_length[WIDX_BITS-1:0]] <= in_byte;
        end
      end else if (!cont && (is_alpha || in_byte == 8'h5f)) begin
        word_chars[0] <= in_byte;
      end
    end
  end

endmodule

>>> src/tkn_queue.sv
// Four-entry token queue: takes up to two tokens per cycle, releases one.
// Depends on tkn_pkg.
module tkn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  tkn_pkg::token_t rec0,
  input  tkn_pkg::token_t rec1,
  input  logic            pop,
  output logic            has_room,
  output logic            not_empty,
  output tkn_pkg::token_t head
);
  import tkn_pkg::*;

  localparam int DEPTH    = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  token_t              mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign has_room  = count <= CNT_BITS'(DEPTH - 2);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_BITS'(push_count);
      rd_ptr <= rd_ptr + PTR_BITS'(pop);
      count  <= count + CNT_BITS'(push_count) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= rec0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + PTR_BITS'(1)] <= rec1;
    end
  end

endmodule

>>> src/command_line_tokenizer.sv
// Command line tokenizer top level: byte in, tokens out through a small queue.
// Each token is registered into the token queue and is offered once it reaches the queue head.
// Throughput: one byte per cycle; byte_ready drops while the token queue holds
// more than two entries, since one byte can produce two tokens.
// Reset (rst, synchronous): position 1:1, offset 0, no pending token, queue empty.
// Depends on tkn_pkg, tkn_scan and tkn_queue.
module command_line_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  in_byte,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [4:0]  token_kind,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [15:0] start_offset,
  output logic [15:0] token_length,
  output logic        last_of_run
);
  import tkn_pkg::*;

  logic       fire;
  logic [1:0] push_count;
  token_t     rec0, rec1, head;

  assign fire = byte_valid && byte_ready;

  tkn_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .in_byte    (in_byte),
    .push_count (push_count),
    .rec0       (rec0),
    .rec1       (rec1)
  );

  tkn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .rec0       (rec0),
    .rec1       (rec1),
    .pop        (token_valid && token_ready),
    .has_room   (byte_ready),
    .not_empty  (token_valid),
    .head       (head)
  );

  assign token_kind   = head.kind;
  assign start_line   = head.line;
  assign start_column = head.column;
  assign start_offset = head.offset;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule

>>> verif/testbench.sv
// Testbench for command_line_tokenizer: byte stream in, token stream out.
// A scoreboard predicts every token from the accepted bytes and checks each token transfer.
// Depends on tkn_pkg and the command_line_tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
  import tkn_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD} scan_t;

  class token_scoreboard;
    string       kw_names[KW_COUNT];
    scan_t       mode;
    logic [7:0]  word_buf[KW_CHARS];
    logic [15:0] run_len, run_line, run_col, run_off;
    logic [15:0] line, col, offset;
    token_t      expected_q[$];
    int          errors;

    function new();
      kw_names = '{"help", "save", "read", "add", "undo", "redo", "ls", "con", "cd", "cur",
                   "disconnect", "set", "hist", "state"};
      errors = 0;
      restart();
    endfunction

    function void restart();
      mode = SCAN_IDLE;
      foreach (word_buf[i]) word_buf[i] = 8'h00;
      run_len  = 16'd0;
      run_line = 16'd1;
      run_col  = 16'd1;
      run_off  = 16'd0;
      line     = 16'd1;
      col      = 16'd1;
      offset   = 16'd0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    function void advance(logic [7:0] b);
      offset = bump(offset);
      if (b == 8'h0a) begin
        line = bump(line);
        col  = 16'd1;
      end else begin
        col = bump(col);
      end
    endfunction

    function kind_t word_kind();
      kind_t k;
      logic  hit;
      string name;
      k = KIND_IDENT;
      if (run_len <= KW_CHARS) begin
        for (int w = 0; w < KW_COUNT; w++) begin
          name = kw_names[w];
          hit = (name.len() == run_len);
          for (int i = 0; i < name.len(); i++) begin
            if (word_buf[i] != name[i]) hit = 1'b0;
          end
          if (hit && k == KIND_IDENT) k = KIND_FIRST_KW + kind_t'(w);
        end
      end
      return k;
    endfunction

    function void push(kind_t k, logic [15:0] l, logic [15:0] c, logic [15:0] o,
                       logic [15:0] n, logic last);
      token_t t;
      t.kind   = k;
      t.line   = l;
      t.column = c;
      t.offset = o;
      t.length = n;
      t.last   = last;
      expected_q.push_back(t);
    endfunction

    function void tokenize_byte(logic [7:0] b);
      logic  digit, alpha, space, word_part, single;
      kind_t k;
      digit     = (b >= "0" && b <= "9");
      alpha     = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
      space     = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
      word_part = alpha || digit || b == "_";
      single    = !(space || word_part);
      if (mode == SCAN_NUMBER && digit) begin
        run_len = bump(run_len);
        advance(b);
        return;
      end
      if (mode == SCAN_WORD && word_part) begin
        if (run_len < KW_CHARS) word_buf[run_len] = b;
        run_len = bump(run_len);
        advance(b);
        return;
      end
      if (mode != SCAN_IDLE) begin
        k = (mode == SCAN_NUMBER) ? KIND_NUMBER : word_kind();
        push(k, run_line, run_col, run_off, run_len, !single);
        mode    = SCAN_IDLE;
        run_len = 16'd0;
      end
      if (b == 8'h00) begin
        push(KIND_END, line, col, offset, 16'd0, 1'b1);
        restart();
      end else if (space) begin
        advance(b);
      end else if (word_part) begin
        mode     = digit ? SCAN_NUMBER : SCAN_WORD;
        run_len  = 16'd1;
        run_line = line;
        run_col  = col;
        run_off  = offset;
        foreach (word_buf[i]) word_buf[i] = 8'h00;
        word_buf[0] = b;
        advance(b);
      end else begin
        case (b)
          "-":     k = KIND_DASH;
          ".":     k = KIND_DOT;
          ":":     k = KIND_COLON;
          ";":     k = KIND_SEMI;
          "=":     k = KIND_EQUAL;
          "/":     k = KIND_SLASH;
          default: k = KIND_UNKNOWN;
        endcase
        push(k, line, col, offset, 16'd1, 1'b1);
        advance(b);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected token, expected none, actual kind %0d at %0d:%0d",
                 $time, got.kind, got.line, got.column);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("token_kind", 16'(want.kind), 16'(got.kind));
      compare_field("start_line", want.line, got.line);
      compare_field("start_column", want.column, got.column);
      compare_field("start_offset", want.offset, got.offset);
      compare_field("token_length", want.length, got.length);
      compare_field("last_of_run", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        token_valid;
  logic        token_ready = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;

  bit              src_idle = 1'b1;
  bit              snk_idle = 1'b1;
  int              sent_count = 0;
  int              kw_turn = 0;
  logic [7:0]      opening[25];
  token_scoreboard sb = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  command_line_tokenizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .in_byte      (in_byte),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .start_line   (start_line),
    .start_column (start_column),
    .start_offset (start_offset),
    .token_length (token_length),
    .last_of_run  (last_of_run)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (token_valid && token_ready) begin
        sb.check_token({token_kind, start_line, start_column, start_offset, token_length,
                        last_of_run});
      end
      if (byte_valid && byte_ready) sb.tokenize_byte(in_byte);
    end
  end

  function automatic int draw_wait(bit enabled);
    return enabled ? int'($urandom_range(0, 16)) : 0;
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_wait(src_idle);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    in_byte    <= b;
    do @(posedge clk); while (!byte_ready);
    sent_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] lead_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] space_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? 8'h20 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] unknown_char();
    string symbols;
    int    r;
    symbols = "!#$%&*+,<>?@[]^`{|}~";
    r = $urandom_range(0, 2);
    if (r == 0) return 8'($urandom_range(128, 255));
    if (r == 1) return 8'($urandom_range(1, 8));
    return symbols[$urandom_range(0, symbols.len() - 1)];
  endfunction

  // near-keywords, over-long words and plain identifiers
  task automatic send_word();
    string kw;
    int    variant, n, pos;
    variant = $urandom_range(0, 5);
    kw = sb.kw_names[$urandom_range(0, KW_COUNT - 1)];
    case (variant)
      0: begin
        send_text(kw);
        send_byte(word_char());
      end
      1: begin
        for (int i = 0; i < kw.len() - 1; i++) send_byte(kw[i]);
      end
      2: begin
        pos = $urandom_range(0, kw.len() - 1);
        for (int i = 0; i < kw.len(); i++) send_byte((i == pos) ? kw[i] - 8'd32 : kw[i]);
      end
      3: begin
        send_text("disconnect");
        repeat ($urandom_range(0, 4)) send_byte(word_char());
      end
      default: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        send_byte(lead_char());
        repeat (n - 1) send_byte(word_char());
      end
    endcase
  endtask

  task automatic random_command();
    string punct;
    int    count, r;
    punct = "-.:;=/";
    count = $urandom_range(0, 8);
    src_idle = ($urandom_range(0, 3) != 0);
    snk_idle = ($urandom_range(0, 3) != 0);
    for (int t = 0; t < count; t++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_text(sb.kw_names[kw_turn % KW_COUNT]);
        kw_turn++;
      end else if (r < 40) begin
        send_word();
      end else if (r < 55) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(48, 57)));
      end else if (r < 75) begin
        send_byte(punct[$urandom_range(0, 5)]);
      end else if (r < 85) begin
        send_byte(unknown_char());
      end else begin
        send_byte(8'($urandom_range(1, 255)));
      end
      repeat (($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 2)) send_byte(space_char());
    end
    send_byte(8'h00);
  endtask

  initial begin
    int stall;
    forever begin
      stall = draw_wait(snk_idle);
      if (stall > 0) begin
        token_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      token_ready <= 1'b1;
      do @(posedge clk); while (token_valid !== 1'b1);
    end
  end

  initial begin
    opening = '{"4", "2", 8'h09, "x", "_", "9", 8'h80, "-", ".", ":", ";", "=", "/", " ",
                8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'hff, 8'h7f, "7", 8'h00, 8'h00, "_", 8'h00};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (opening[i]) send_byte(opening[i]);
    while (sent_count < 460) random_command();
    // saturate length, column, offset and then line in one long command
    src_idle = 1'b0;
    snk_idle = 1'b0;
    repeat (65540) send_byte("9");
    send_byte(".");
    repeat (65540) send_byte(8'h0a);
    send_text("ab-");
    send_byte(8'h00);
    send_text("x");
    send_byte(8'h00);
    byte_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
src/tkn_pkg.sv
src/tkn_scan.sv
src/tkn_queue.sv
src/command_line_tokenizer.sv
verif/testbench.sv
